### rtl/rte_pkg.sv
// shared types and codes for the route table engine
package rte_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // input actions
  localparam logic [2:0] ACT_RREQ = 3'd0;
  localparam logic [2:0] ACT_RREP = 3'd1;
  localparam logic [2:0] ACT_RERR = 3'd2;
  localparam logic [2:0] ACT_DATA = 3'd3;
  localparam logic [2:0] ACT_LINK = 3'd4;

  // result kinds
  localparam logic [2:0] K_RREQ    = 3'd0;
  localparam logic [2:0] K_RREP    = 3'd1;
  localparam logic [2:0] K_RERR    = 3'd2;
  localparam logic [2:0] K_ACK     = 3'd3;
  localparam logic [2:0] K_FWD     = 3'd4;
  localparam logic [2:0] K_LOCAL   = 3'd5;
  localparam logic [2:0] K_NOROUTE = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_HEAD = 2'd2;

  localparam logic [15:0] MAC_BCAST = 16'hFFFF;

  typedef struct packed {
    logic [7:0] my_addr;
    logic [7:0] base_addr;
    logic       is_cluster_head;
  } cfg_t;

  // first field in the highest bits
  typedef struct packed {
    logic [15:0] mac_src;
    logic [7:0]  src_id;
    logic [7:0]  dest_id;
    logic [15:0] seq_index;
    logic [2:0]  action;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic [7:0]  out_src;
    logic [7:0]  out_dest;
    logic [15:0] out_index;
    logic [15:0] mac_dest;
    logic [2:0]  kind;
  } result_t;

  typedef struct packed {
    logic [7:0]  dest;
    logic [15:0] hop;
    logic [15:0] seq;
  } route_entry_t;

  typedef struct packed {
    logic       load;
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } obuf_load_t;

endpackage

### rtl/rte_mem.sv
// route table storage: one write port, one registered read port
module rte_mem #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output rte_pkg::route_entry_t      rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  rte_pkg::route_entry_t      wr_data
);
  import rte_pkg::*;

  route_entry_t mem [DEPTH];
  route_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rte_obuf.sv
// two-entry result buffer in front of the output channel
module rte_obuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rte_pkg::obuf_load_t     load,
  output logic                    empty,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rte_pkg::result_t        out_res
);
  import rte_pkg::*;

  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic [1:0] n_r, n_nxt;

  assign empty     = (n_r == 2'd0);
  assign out_valid = !empty;
  assign out_res   = slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    n_nxt     = n_r;
    if (load.load) begin
      slot0_nxt = load.res0;
      slot1_nxt = load.res1;
      n_nxt     = load.num;
    end else if (out_valid && out_ready) begin
      slot0_nxt = slot1_r;
      n_nxt     = n_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 2'd0;
    end else begin
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load.load |-> n_r == 2'd0)
    else $error("result buffer loaded while holding results");

endmodule

### rtl/rte_ctrl.sv
// sequencer: table scans, route update and result assembly
module rte_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rte_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rte_pkg::in_item_t          in_item,
  output logic                       mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
  input  rte_pkg::route_entry_t      mem_rd_data,
  output logic                       mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
  output rte_pkg::route_entry_t      mem_wr_data,
  input  logic                       obuf_empty,
  output rte_pkg::obuf_load_t        obuf_load
);
  import rte_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  localparam logic PH_UPD  = 1'b0;
  localparam logic PH_LOOK = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_UPD  = 5'b00100,
    S_LOOK = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic         phase_r, phase_nxt;
  in_item_t     item_r, item_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]  own_seq_r, own_seq_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic         pend_r, pend_nxt;
  logic [IW-1:0] cmp_slot_r, cmp_slot_nxt;
  logic         found_r, found_nxt;
  logic [IW-1:0] hit_slot_r, hit_slot_nxt;
  route_entry_t hit_r, hit_nxt;
  result_t      res0_r, res0_nxt;
  result_t      res1_r, res1_nxt;
  logic [1:0]   num_r, num_nxt;

  logic [7:0]   scan_key;
  logic [15:0]  my_mac;
  logic         upd_ok;

  function automatic result_t mk_res(logic [2:0] kind, logic [15:0] mac, logic [15:0] idx,
                                     logic [7:0] dst, logic [7:0] src, logic last);
    result_t r;
    r.kind      = kind;
    r.mac_dest  = mac;
    r.out_index = idx;
    r.out_dest  = dst;
    r.out_src   = src;
    r.last      = last;
    return r;
  endfunction

  assign scan_key = (phase_r == PH_LOOK) ? item_r.dest_id : item_r.src_id;
  assign my_mac   = {8'd0, cfg.my_addr};
  assign upd_ok   = !found_r || (item_r.seq_index > hit_r.seq);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    item_nxt     = item_r;
    count_nxt    = count_r;
    own_seq_nxt  = own_seq_r;
    issue_nxt    = issue_r;
    pend_nxt     = pend_r;
    cmp_slot_nxt = cmp_slot_r;
    found_nxt    = found_r;
    hit_slot_nxt = hit_slot_r;
    hit_nxt      = hit_r;
    res0_nxt     = res0_r;
    res1_nxt     = res1_r;
    num_nxt      = num_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = issue_r[IW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = count_r[IW-1:0];
    mem_wr_data  = '{dest: item_r.src_id, hop: item_r.mac_src, seq: item_r.seq_index};
    obuf_load    = '0;

    case (state_r)
      S_IDLE: begin
        issue_nxt = '0;
        pend_nxt  = 1'b0;
        if (in_valid) begin
          item_nxt = in_item;
          res0_nxt = mk_res(K_ACK, in_item.mac_src, in_item.seq_index, in_item.dest_id,
                            in_item.src_id, 1'b1);
          num_nxt  = 2'd0;
          case (in_item.action)
            ACT_RREQ, ACT_RREP: begin
              num_nxt = 2'd1;
              if (count_r == COUNT_FULL) begin
                state_nxt = S_EMIT;
              end else begin
                phase_nxt = PH_UPD;
                state_nxt = S_SCAN;
              end
            end
            ACT_RERR: begin
              if (in_item.dest_id != cfg.my_addr) begin
                phase_nxt = PH_LOOK;
                state_nxt = S_SCAN;
              end
            end
            ACT_DATA: begin
              if (in_item.dest_id == cfg.my_addr) begin
                res0_nxt  = mk_res(K_LOCAL, my_mac, 16'd0, in_item.dest_id,
                                   in_item.src_id, 1'b1);
                num_nxt   = 2'd1;
                state_nxt = S_EMIT;
              end else begin
                phase_nxt = PH_LOOK;
                state_nxt = S_SCAN;
              end
            end
            ACT_LINK: begin
              if (cfg.is_cluster_head) begin
                phase_nxt = PH_LOOK;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // one read issued per cycle, the entry read in the previous cycle compared
      S_SCAN: begin
        if (pend_r && mem_rd_data.dest == scan_key) begin
          found_nxt    = 1'b1;
          hit_slot_nxt = cmp_slot_r;
          hit_nxt      = mem_rd_data;
          pend_nxt     = 1'b0;
          state_nxt    = (phase_r == PH_LOOK) ? S_LOOK : S_UPD;
        end else if (issue_r != count_r) begin
          mem_rd_en    = 1'b1;
          pend_nxt     = 1'b1;
          cmp_slot_nxt = issue_r[IW-1:0];
          issue_nxt    = issue_r + CW'(1);
        end else begin
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = (phase_r == PH_LOOK) ? S_LOOK : S_UPD;
        end
      end

      S_UPD: begin
        state_nxt = S_EMIT;
        if (!found_r) begin
          mem_wr_en = 1'b1;
          count_nxt = count_r + CW'(1);
        end else if (upd_ok) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = hit_slot_r;
        end
        if (upd_ok) begin
          if (item_r.action == ACT_RREQ) begin
            if (item_r.dest_id == cfg.my_addr) begin
              // route to the source now points at the sender
              own_seq_nxt   = own_seq_r + 16'd1;
              res0_nxt.last = 1'b0;
              res1_nxt      = mk_res(K_RREP, item_r.mac_src, own_seq_r + 16'd1,
                                     item_r.src_id, item_r.dest_id, 1'b1);
              num_nxt       = 2'd2;
            end else if (item_r.src_id != cfg.my_addr) begin
              res0_nxt.last = 1'b0;
              res1_nxt      = mk_res(K_RREQ, MAC_BCAST, item_r.seq_index,
                                     item_r.dest_id, item_r.src_id, 1'b1);
              num_nxt       = 2'd2;
            end
          end else if (item_r.dest_id != cfg.my_addr) begin
            issue_nxt = '0;
            pend_nxt  = 1'b0;
            phase_nxt = PH_LOOK;
            state_nxt = S_SCAN;
          end
        end
      end

      S_LOOK: begin
        state_nxt = S_EMIT;
        case (item_r.action)
          ACT_RREP: begin
            if (found_r) begin
              res0_nxt.last = 1'b0;
              res1_nxt      = mk_res(K_RREP, hit_r.hop, item_r.seq_index,
                                     item_r.dest_id, item_r.src_id, 1'b1);
              num_nxt       = 2'd2;
            end
          end
          ACT_RERR, ACT_LINK: begin
            res0_nxt = mk_res(K_RERR, hit_r.hop, 16'd0, item_r.dest_id, cfg.my_addr, 1'b1);
            num_nxt  = found_r ? 2'd1 : 2'd0;
          end
          ACT_DATA: begin
            num_nxt = 2'd1;
            if (found_r) begin
              res0_nxt = mk_res(K_FWD, hit_r.hop, 16'd0, item_r.dest_id,
                                item_r.src_id, 1'b1);
            end else if (cfg.is_cluster_head) begin
              res0_nxt    = mk_res(K_RREQ, MAC_BCAST, own_seq_r, cfg.base_addr,
                                   cfg.my_addr, 1'b1);
              own_seq_nxt = own_seq_r + 16'd1;
            end else begin
              res0_nxt = mk_res(K_NOROUTE, 16'd0, 16'd0, item_r.dest_id,
                                item_r.src_id, 1'b1);
            end
          end
          default: begin
            num_nxt = 2'd0;
          end
        endcase
      end

      S_EMIT: begin
        if (num_r == 2'd0) begin
          state_nxt = S_IDLE;
        end else if (obuf_empty) begin
          obuf_load.load = 1'b1;
          obuf_load.num  = num_r;
          obuf_load.res0 = res0_r;
          obuf_load.res1 = res1_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      own_seq_r <= 16'd1;
      pend_r    <= 1'b0;
      num_r     <= 2'd0;
      phase_r   <= PH_UPD;
      issue_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      own_seq_r <= own_seq_nxt;
      pend_r    <= pend_nxt;
      num_r     <= num_nxt;
      phase_r   <= phase_nxt;
      issue_r   <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    found_r    <= found_nxt;
    hit_slot_r <= hit_slot_nxt;
    hit_r      <= hit_nxt;
    res0_r     <= res0_nxt;
    res1_r     <= res1_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("route count above table depth");

  a_wr_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (CW'(mem_wr_addr) <= count_r) && (count_r != COUNT_FULL))
    else $error("table write outside filled region or into full table");

  a_cmp_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r) |-> CW'(cmp_slot_r) < count_r)
    else $error("scan compared an unfilled entry");

endmodule

### rtl/aodv_route_table_engine_top.sv
// route table engine top level: config registers, sequencer, table, result buffer
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | in_tuser: action
//          |           |                    | in_tdata: seq_index, dest_id, src_id, mac_src
//  out_    | output    | out_tvalid/tready  | out_tuser: kind, out_tlast: last
//          |           |                    | out_tdata: mac_dest, out_index, out_dest, out_src
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one item at a time; a table scan reads one entry per cycle from the single read
// port; an RREP item may scan twice, for the update and for the forward lookup.
// reset sets the config defaults, empties the table (fill count 0) and sets the own
// sequence index to 1; the memory itself is not cleared, entries past the fill
// count are never read. results sit in a two-entry buffer; the next item is taken
// while they wait and only its own results hold until the buffer drains.
module aodv_route_table_engine_top #(
  parameter int ROUTE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // seq_index[15:0], dest_id[23:16], src_id[31:24], mac_src[47:32]
  input  logic [rte_pkg::IN_DATA_W-1:0]      in_tdata,
  // action[2:0]
  input  logic [rte_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // mac_dest[15:0], out_index[31:16], out_dest[39:32], out_src[47:40]
  output logic [rte_pkg::OUT_DATA_W-1:0]     out_tdata,
  // kind[2:0]
  output logic [rte_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [rte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rte_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rte_pkg::*;

  localparam int IW = $clog2(ROUTE_DEPTH);

  cfg_t         cfg_r, cfg_nxt;
  in_item_t     in_item;
  logic         mem_rd_en;
  logic [IW-1:0] mem_rd_addr;
  route_entry_t mem_rd_data;
  logic         mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  route_entry_t mem_wr_data;
  logic         obuf_empty;
  obuf_load_t   obuf_load;
  result_t      out_res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MY_ADDR:      cfg_nxt.my_addr         = cfg_wdata;
        CFG_BASE_ADDR:    cfg_nxt.base_addr       = cfg_wdata;
        CFG_CLUSTER_HEAD: cfg_nxt.is_cluster_head = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{my_addr: 8'd1, base_addr: 8'd0, is_cluster_head: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item = in_item_t'({in_tdata, in_tuser});

  rte_ctrl #(
    .DEPTH (ROUTE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .obuf_empty  (obuf_empty),
    .obuf_load   (obuf_load)
  );

  rte_mem #(
    .DEPTH (ROUTE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  rte_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (obuf_load),
    .empty     (obuf_empty),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.out_src, out_res.out_dest, out_res.out_index, out_res.mac_dest};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

### sim/aodv_route_checker.sv
// route table engine checker: mirrors the route table, predicts emitted packets, compares
module aodv_route_checker #(
  parameter int ROUTE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [rte_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [rte_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [rte_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [rte_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import rte_pkg::*;

  logic        rt_valid [ROUTE_DEPTH];
  logic [7:0]  rt_dest  [ROUTE_DEPTH];
  logic [15:0] rt_hop   [ROUTE_DEPTH];
  logic [15:0] rt_seq   [ROUTE_DEPTH];
  int          rt_fill;
  logic [15:0] seq_own;
  cfg_t        node_cfg;

  result_t     due_packets [$];
  int          errs;

  function automatic int find_route(logic [7:0] id);
    for (int i = 0; i < ROUTE_DEPTH; i++) begin
      if (rt_valid[i] && rt_dest[i] == id) return i;
    end
    return -1;
  endfunction

  // insert, or refresh on a strictly newer index; a full table refuses both
  function automatic bit learn_route(logic [7:0] id, logic [15:0] seq, logic [15:0] hop);
    int s;
    s = find_route(id);
    if (rt_fill >= ROUTE_DEPTH) return 1'b0;
    if (s < 0) begin
      for (int i = 0; i < ROUTE_DEPTH; i++) begin
        if (!rt_valid[i]) begin
          rt_valid[i] = 1'b1;
          rt_dest[i]  = id;
          rt_hop[i]   = hop;
          rt_seq[i]   = seq;
          rt_fill++;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (seq > rt_seq[s]) begin
      rt_hop[s] = hop;
      rt_seq[s] = seq;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t pkt(logic [2:0] k, logic [15:0] mac, logic [15:0] idx,
                                  logic [7:0] dst, logic [7:0] src);
    result_t r;
    r.kind      = k;
    r.mac_dest  = mac;
    r.out_index = idx;
    r.out_dest  = dst;
    r.out_src   = src;
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic predict_packets(in_item_t it);
    result_t outs [2];
    int      n;
    int      s;
    bit      learned;
    n = 0;
    case (it.action)
      ACT_RREQ: begin
        outs[n] = pkt(K_ACK, it.mac_src, it.seq_index, it.dest_id, it.src_id);
        n++;
        learned = learn_route(it.src_id, it.seq_index, it.mac_src);
        if (learned && it.dest_id == node_cfg.my_addr) begin
          seq_own = seq_own + 16'd1;
          s = find_route(it.src_id);
          if (s >= 0) begin
            outs[n] = pkt(K_RREP, rt_hop[s], seq_own, it.src_id, it.dest_id);
            n++;
          end
        end else if (learned && it.src_id != node_cfg.my_addr) begin
          outs[n] = pkt(K_RREQ, MAC_BCAST, it.seq_index, it.dest_id, it.src_id);
          n++;
        end
      end
      ACT_RREP: begin
        outs[n] = pkt(K_ACK, it.mac_src, it.seq_index, it.dest_id, it.src_id);
        n++;
        learned = learn_route(it.src_id, it.seq_index, it.mac_src);
        if (learned && it.dest_id != node_cfg.my_addr) begin
          s = find_route(it.dest_id);
          if (s >= 0) begin
            outs[n] = pkt(K_RREP, rt_hop[s], it.seq_index, it.dest_id, it.src_id);
            n++;
          end
        end
      end
      ACT_RERR, ACT_LINK: begin
        // a dropped link skips the own-address test but needs cluster head mode
        s = find_route(it.dest_id);
        if (s >= 0 && ((it.action == ACT_RERR && it.dest_id != node_cfg.my_addr) ||
                       (it.action == ACT_LINK && node_cfg.is_cluster_head))) begin
          outs[n] = pkt(K_RERR, rt_hop[s], 16'd0, it.dest_id, node_cfg.my_addr);
          n++;
        end
      end
      ACT_DATA: begin
        s = find_route(it.dest_id);
        if (it.dest_id == node_cfg.my_addr) begin
          outs[n] = pkt(K_LOCAL, {8'd0, node_cfg.my_addr}, 16'd0, it.dest_id, it.src_id);
        end else if (s >= 0) begin
          outs[n] = pkt(K_FWD, rt_hop[s], 16'd0, it.dest_id, it.src_id);
        end else if (node_cfg.is_cluster_head) begin
          outs[n] = pkt(K_RREQ, MAC_BCAST, seq_own, node_cfg.base_addr, node_cfg.my_addr);
          seq_own = seq_own + 16'd1;
        end else begin
          outs[n] = pkt(K_NOROUTE, 16'd0, 16'd0, it.dest_id, it.src_id);
        end
        n++;
      end
      default: ;
    endcase
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_packets.push_back(outs[i]);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  initial errs = 0;

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ROUTE_DEPTH; i++) begin
        rt_valid[i] = 1'b0;
        rt_dest[i]  = '0;
        rt_hop[i]   = '0;
        rt_seq[i]   = '0;
      end
      rt_fill                  = 0;
      seq_own                  = 16'd1;
      node_cfg.my_addr         = 8'd1;
      node_cfg.base_addr       = 8'd0;
      node_cfg.is_cluster_head = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MY_ADDR:      node_cfg.my_addr = cfg_wdata;
          CFG_BASE_ADDR:    node_cfg.base_addr = cfg_wdata;
          CFG_CLUSTER_HEAD: node_cfg.is_cluster_head = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata, out_tuser};
        if (due_packets.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d mac_dest %0d",
                 got.kind, got.mac_dest);
          errs++;
        end else begin
          want = due_packets.pop_front();
          check_field("kind", 16'(want.kind), 16'(got.kind));
          check_field("mac_dest", want.mac_dest, got.mac_dest);
          check_field("out_index", want.out_index, got.out_index);
          check_field("out_dest", 16'(want.out_dest), 16'(got.out_dest));
          check_field("out_src", 16'(want.out_src), 16'(got.out_src));
          check_field("last", 16'(want.last), 16'(got.last));
        end
      end
      if (in_tvalid && in_tready) predict_packets(in_item_t'({in_tdata, in_tuser}));
    end
    mismatches  <= errs;
    outstanding <= due_packets.size();
  end

endmodule

### sim/tb_top.sv
// testbench top for the route table engine: stimulus, receiver stalls, watchdog, verdict
module tb_top;
  import rte_pkg::*;

  localparam int ROUTE_DEPTH    = 16;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_N         = 12;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int outstanding;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aodv_route_table_engine_top #(.ROUTE_DEPTH(ROUTE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  aodv_route_checker #(.ROUTE_DEPTH(ROUTE_DEPTH)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // receiver stall patterns
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;
  rx_mode_t rx_mode;
  int       rx_mode_left = 0;
  int       rx_stall_left = 0;

  always @(posedge clk) begin
    logic ready_next;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(40, 400);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:   ready_next = 1'b1;
      RX_COIN:   ready_next = 1'($urandom_range(0, 1));
      RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(5, 20);
        end
      end
    endcase
    out_tready <= ready_next;
  end

  // no transfer on either channel for too long ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

  logic [7:0]  cur_my = 8'd1;
  logic [7:0]  pool [POOL_N];
  logic [15:0] last_seq [256];
  int          burst_left = 0;

  function automatic in_item_t item(logic [2:0] act, logic [15:0] seq, logic [7:0] dst,
                                    logic [7:0] src, logic [15:0] mac);
    in_item_t it;
    it.action    = act;
    it.seq_index = seq;
    it.dest_id   = dst;
    it.src_id    = src;
    it.mac_src   = mac;
    return it;
  endfunction

  // mostly newer than the last index sent for this source, so refreshes happen
  function automatic logic [15:0] fresh_seq(logic [7:0] src);
    logic [15:0] s;
    case ($urandom_range(0, 9))
      0:       s = 16'h0000;
      1:       s = 16'hFFFF;
      2:       s = last_seq[src];
      3, 4:    s = 16'($urandom);
      default: s = last_seq[src] + 16'($urandom_range(1, 64));
    endcase
    last_seq[src] = s;
    return s;
  endfunction

  function automatic in_item_t random_item(bit open_src);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 30) it.action = ACT_RREQ;
    else if (r < 55) it.action = ACT_RREP;
    else if (r < 65) it.action = ACT_RERR;
    else if (r < 85) it.action = ACT_DATA;
    else if (r < 95) it.action = ACT_LINK;
    else it.action = ACT_LINK + 3'($urandom_range(1, 3));
    // a closed source pool keeps the table below full so refreshes keep working
    r = $urandom_range(0, 99);
    if (open_src && r < 50) it.src_id = 8'($urandom);
    else if (r > 94) it.src_id = cur_my;
    else it.src_id = pool[$urandom_range(0, POOL_N-1)];
    r = $urandom_range(0, 99);
    if (r < 25) it.dest_id = cur_my;
    else if (r < 75) it.dest_id = pool[$urandom_range(0, POOL_N-1)];
    else it.dest_id = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) it.mac_src = MAC_BCAST;
    else if (r < 10) it.mac_src = 16'h0000;
    else it.mac_src = 16'($urandom);
    it.seq_index = fresh_seq(it.src_id);
    return it;
  endfunction

  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5:             gap = $urandom_range(20, 60);
        default:       gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid            <= 1'b1;
    {in_tdata, in_tuser} <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait for every expected result, then for any item still being worked on
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] my, logic [7:0] base, logic head);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MY_ADDR;
    cfg_wdata <= my;
    @(posedge clk);
    cfg_index <= CFG_BASE_ADDR;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_CLUSTER_HEAD;
    cfg_wdata <= {7'd0, head};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_my = my;
  endtask

  task automatic run_phase(logic [7:0] my, logic [7:0] base, logic head, int count,
                           bit open_src);
    set_config(my, base, head);
    repeat (count) send(random_item(open_src));
  endtask

  initial begin
    for (int i = 0; i < 256; i++) last_seq[i] = '0;
    pool[0] = 8'h00;
    pool[1] = 8'h01;
    pool[2] = 8'h30;
    pool[3] = 8'h31;
    pool[4] = 8'h32;
    pool[5] = 8'hFF;
    for (int i = 6; i < POOL_N; i++) pool[i] = 8'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: own id 1, not a cluster head
    send(item(ACT_DATA, 16'h0000, 8'h05, 8'h22, 16'h0000));  // no route
    send(item(ACT_DATA, 16'h0000, 8'h01, 8'h22, 16'h0000));  // delivered locally
    send(item(ACT_RERR, 16'h0000, 8'h05, 8'h22, 16'h0000));  // rerr, no route
    send(item(ACT_LINK, 16'h0000, 8'h05, 8'h22, 16'h0000));  // link drop, not head
    send(item(ACT_RREQ, 16'h0000, 8'h01, 8'h00, 16'h0000));  // rreq for me, new route
    send(item(ACT_RREQ, 16'h0000, 8'h01, 8'h00, 16'h1111));  // stale index, ack only
    send(item(ACT_RREQ, 16'hFFFF, 8'h20, 8'hFF, 16'hFFFF));  // rebroadcast
    send(item(ACT_RREQ, 16'h0005, 8'h20, 8'h01, 16'h1234));  // own source
    send(item(ACT_RREP, 16'h0007, 8'h01, 8'h30, 16'hABCD));  // rrep for me
    send(item(ACT_RREP, 16'h0009, 8'h77, 8'h31, 16'h5555));  // forward, no route
    send(item(ACT_RREP, 16'h8000, 8'hFF, 8'h32, 16'h00FF));  // forward along route
    send(item(ACT_RERR, 16'h0000, 8'hFF, 8'h22, 16'h0000));  // rerr along route
    send(item(ACT_RERR, 16'h0000, 8'h01, 8'h22, 16'h0000));  // rerr for own id
    send(item(ACT_DATA, 16'h0000, 8'hFF, 8'h80, 16'h0000));  // forward data
    send(item(ACT_RREQ, 16'h0001, 8'h01, 8'h00, 16'h2222));  // newer index refreshes
    for (int k = 1; k <= 3; k++) begin
      send(item(ACT_LINK + 3'(k), 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
    end

    set_config(8'h01, 8'h00, 1'b1);
    send(item(ACT_DATA, 16'h0000, 8'h99, 8'h22, 16'h0000));  // route restart
    send(item(ACT_LINK, 16'h0000, 8'hFF, 8'h22, 16'h0000));  // link drop with route
    send(item(ACT_LINK, 16'h0000, 8'h99, 8'h22, 16'h0000));  // link drop, no route
    send(item(ACT_LINK, 16'h0000, 8'h01, 8'h22, 16'h0000));  // no own-id test
    send(item(ACT_RERR, 16'h0000, 8'h99, 8'h22, 16'h0000));

    run_phase(8'h00, 8'hFF, 1'b1, 250, 1'b0);
    run_phase(8'hFF, 8'h00, 1'b0, 250, 1'b0);
    run_phase(pool[$urandom_range(0, POOL_N-1)], 8'($urandom), 1'b1, 250, 1'b0);
    run_phase(pool[$urandom_range(0, POOL_N-1)], 8'($urandom), 1'b0, 250, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 1'b1, 250, 1'b0);
    run_phase(pool[$urandom_range(0, POOL_N-1)], 8'hFF, 1'b1, 250, 1'b0);
    // open sources fill the table, then every update is refused
    run_phase(8'($urandom), 8'($urandom), 1'b0, 300, 1'b1);
    run_phase(pool[$urandom_range(0, POOL_N-1)], 8'h00, 1'b1, 300, 1'b1);

    settle();
    if (mismatches == 0 && outstanding == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
